@@ hdl/assert_macros.svh @@
// Assertion macros for the RTL checks in last_note_priority_stack.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define LNPS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next cycle.
`define LNPS_ASSERT_NEXT(lbl, cond, nxt, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (nxt)) \
      else $error(msg);

`endif

@@ hdl/lnps_pkg.sv @@
// Package: types and constants for the last-note priority stack.
package lnps_pkg;

   localparam int MAX_NOTES = 128;
   localparam int NOTE_W    = 7;
   localparam int LEN_W     = 8;
   localparam int ADDR_W    = 7;

   localparam logic [1:0] REQ_NOTE_ON  = 2'd0;
   localparam logic [1:0] REQ_NOTE_OFF = 2'd1;

   typedef struct packed {
      logic [1:0]        req_type;
      logic [NOTE_W-1:0] note_number;
   } req_word_type;

   typedef struct packed {
      logic [LEN_W-1:0]  held_count;
      logic              any_held;
      logic [NOTE_W-1:0] newest_note;
   } rsp_word_type;

   // command from the control side to the list walker
   typedef struct packed {
      logic              go;
      logic [1:0]        kind;
      logic [NOTE_W-1:0] note;
      logic [LEN_W-1:0]  len;
   } walk_cmd_type;

   // completion status from the list walker
   typedef struct packed {
      logic              done;
      logic              found;
      logic [NOTE_W-1:0] last_kept;
   } walk_sts_type;

endpackage

@@ hdl/lnps_ram.sv @@
// Generic single write port, single registered read port RAM.
module lnps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/lnps_walker.sv @@
// List walker: scans the note list, closes the gap left by a match and appends on note-on.
module lnps_walker
   import lnps_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  walk_cmd_type cmd,
   output walk_sts_type sts
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [LEN_W-1:0]  cnt_ff, cnt_in;
   logic              pend_ff, pend_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic              found_ff, found_in;
   logic [NOTE_W-1:0] last_kept_ff, last_kept_in;
   logic [1:0]        kind_ff, kind_in;
   logic [NOTE_W-1:0] note_ff, note_in;
   logic [LEN_W-1:0]  len_ff, len_in;

   logic              rd_en;
   logic [NOTE_W-1:0] rd_data;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [NOTE_W-1:0] wr_data;
   logic              hit;
   logic              more;

   lnps_ram #(
      .WIDTH (NOTE_W),
      .DEPTH (MAX_NOTES)
   ) u_list (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (cnt_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // compare units: note match and end-of-list test
   assign hit  = (rd_data == note_ff);
   assign more = (cnt_ff < len_ff);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pend_in      = 1'b0;
      idx_in       = idx_ff;
      found_in     = found_ff;
      last_kept_in = last_kept_ff;
      kind_in      = kind_ff;
      note_in      = note_ff;
      len_in       = len_ff;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = idx_ff - ADDR_W'(1);
      wr_data      = rd_data;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.go) begin
               state_in     = ST_SCAN;
               cnt_in       = '0;
               found_in     = 1'b0;
               last_kept_in = '0;
               kind_in      = cmd.kind;
               note_in      = cmd.note;
               len_in       = cmd.len;
            end
         end
         ST_SCAN: begin
            if (more) begin
               rd_en   = 1'b1;
               pend_in = 1'b1;
               idx_in  = cnt_ff[ADDR_W-1:0];
               cnt_in  = cnt_ff + LEN_W'(1);
            end
            if (pend_ff) begin
               if (hit) begin
                  found_in = 1'b1;
               end else begin
                  last_kept_in = rd_data;
                  // entries past the match slide down one slot
                  wr_en = found_ff;
               end
            end
            if (!more && !pend_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            state_in = ST_IDLE;
            wr_data  = note_ff;
            if (found_ff) begin
               wr_addr = ADDR_W'(len_ff - LEN_W'(1));
            end else begin
               wr_addr = len_ff[ADDR_W-1:0];
            end
            wr_en = (kind_ff == REQ_NOTE_ON) && (found_ff || (len_ff < LEN_W'(MAX_NOTES)));
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
      cnt_ff       <= cnt_in;
      idx_ff       <= idx_in;
      found_ff     <= found_in;
      last_kept_ff <= last_kept_in;
      kind_ff      <= kind_in;
      note_ff      <= note_in;
      len_ff       <= len_in;
   end

   assign sts.done      = (state_ff == ST_FINISH);
   assign sts.found     = found_ff;
   assign sts.last_kept = last_kept_ff;

endmodule

@@ hdl/last_note_priority_stack.sv @@
// Last-note priority stack: held-note list with newest-note report.
// Response: a note-on/off word strobes rsp_valid when the walker's scan of the held
//   list ends; other kinds answer in the cycle after they are taken.
// Throughput: busy covers the whole walk, so the next word is taken no earlier than
//   the note word's response; the receiver cannot stall.
// Reset: synchronous; the list is empty after reset, RAM contents are not cleared.
`include "assert_macros.svh"

module last_note_priority_stack
   import lnps_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_word_type req_data,
   output logic         rsp_valid,
   output rsp_word_type rsp_data
);

   logic             busy_ff, busy_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [NOTE_W-1:0] newest_ff, newest_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_word_type     rsp_ff, rsp_in;

   walk_cmd_type cmd;
   walk_sts_type sts;
   logic         accept;
   logic         is_note;
   logic [1:0]   kind_ff;
   logic [NOTE_W-1:0] note_ff;

   assign accept  = start && !busy_ff;
   assign is_note = (req_data.req_type == REQ_NOTE_ON) ||
                    (req_data.req_type == REQ_NOTE_OFF);

   // launch the walker for note-on/off; other kinds answer straight away
   assign cmd.go   = accept && is_note;
   assign cmd.kind = req_data.req_type;
   assign cmd.note = req_data.note_number;
   assign cmd.len  = len_ff;

   lnps_walker u_walker (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .sts   (sts)
   );

   always_comb begin
      busy_in      = busy_ff;
      len_in       = len_ff;
      newest_in    = newest_ff;
      rsp_valid_in = 1'b0;
      if (cmd.go) begin
         busy_in = 1'b1;
      end
      if (sts.done) begin
         busy_in = 1'b0;
         if (kind_ff == REQ_NOTE_ON) begin
            if (sts.found) begin
               newest_in = note_ff;
            end else if (len_ff < LEN_W'(MAX_NOTES)) begin
               len_in    = len_ff + LEN_W'(1);
               newest_in = note_ff;
            end
         end else if (sts.found) begin
            // note-off: newest surviving entry seen during the scan
            len_in    = len_ff - LEN_W'(1);
            newest_in = sts.last_kept;
         end
      end
      rsp_valid_in = sts.done || (accept && !is_note);
      rsp_in.held_count  = len_in;
      rsp_in.any_held    = (len_in != '0);
      rsp_in.newest_note = (len_in != '0) ? newest_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         len_ff       <= '0;
         newest_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         len_ff       <= len_in;
         newest_ff    <= newest_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
      if (cmd.go) begin
         kind_ff <= req_data.req_type;
         note_ff <= req_data.note_number;
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `LNPS_ASSERT(a_len_bound, len_ff <= LEN_W'(MAX_NOTES), "held count above capacity")
   `LNPS_ASSERT_NEXT(a_go_busy, cmd.go, busy_ff, "walk launched without busy")
   `LNPS_ASSERT_NEXT(a_done_resp, sts.done, rsp_valid_ff && !busy_ff, "walk end without response")
   `LNPS_ASSERT(a_done_in_busy, !sts.done || busy_ff, "walker finished while idle")

endmodule

@@ dv/note_board_pkg.sv @@
// Scoreboard for the held-note stack: predicts and checks each report word.
`timescale 1ns / 1ps

package note_board_pkg;
   import lnps_pkg::*;

   class held_note_board;
      logic [NOTE_W-1:0] held [MAX_NOTES];
      int                held_len;
      rsp_word_type      expected_reports[$];
      int                fail_count;

      function new();
         held_len   = 0;
         fail_count = 0;
         foreach (held[i]) held[i] = '0;
      endfunction

      task report_mismatch(input string what);
         $display("%0t: mismatch: %s", $time, what);
         fail_count++;
      endtask

      // note-on/off update of the held list, oldest entry at index 0; report for any kind
      function rsp_word_type apply_message(input req_word_type w);
         rsp_word_type r;
         int           pos;
         pos = -1;
         if (w.req_type == REQ_NOTE_ON || w.req_type == REQ_NOTE_OFF) begin
            for (int i = 0; i < held_len; i++) begin
               if (pos < 0 && held[i] == w.note_number) pos = i;
            end
            if (pos >= 0) begin
               for (int i = pos; i < held_len - 1; i++) held[i] = held[i + 1];
               held_len--;
            end
            if (w.req_type == REQ_NOTE_ON && held_len < MAX_NOTES) begin
               held[held_len] = w.note_number;
               held_len++;
            end
         end
         r.held_count  = LEN_W'(held_len);
         r.any_held    = (held_len != 0);
         r.newest_note = (held_len != 0) ? held[held_len - 1] : '0;
         return r;
      endfunction

      function void take_word(input req_word_type w);
         rsp_word_type r;
         r                = apply_message(w);
         expected_reports = {expected_reports, r};
      endfunction

      task check_result(input rsp_word_type got);
         rsp_word_type want;
         if (expected_reports.size() == 0) begin
            report_mismatch($sformatf("report word with none expected: %h", got));
         end else begin
            want = expected_reports.pop_front();
            if (got.held_count !== want.held_count)
               report_mismatch($sformatf("held_count %0d, want %0d",
                                         got.held_count, want.held_count));
            if (got.any_held !== want.any_held)
               report_mismatch($sformatf("any_held %b, want %b",
                                         got.any_held, want.any_held));
            if (got.newest_note !== want.newest_note)
               report_mismatch($sformatf("newest_note %0d, want %0d",
                                         got.newest_note, want.newest_note));
         end
      endtask
   endclass

endpackage

@@ dv/testbench.sv @@
// Testbench for the last-note priority stack: directed and random note traffic.
`timescale 1ns / 1ps

module testbench;
   import lnps_pkg::*;
   import note_board_pkg::*;

   // message kinds the block ignores
   localparam logic [1:0] REQ_OTHER = 2'd2;
   localparam logic [1:0] REQ_SPARE = 2'd3;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         start     = 1'b0;
   req_word_type req_data  = '0;
   logic         busy;
   logic         rsp_valid;
   rsp_word_type rsp_data;

   held_note_board    board;
   int                idle_pct;   // chance (percent) of a gap before each word
   logic [NOTE_W-1:0] order [MAX_NOTES];

   last_note_priority_stack i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Monitor: sample at the rising edge. The block updates its outputs with
   // nonblocking assignments, so busy and rsp_* read here are pre-edge values.
   // The report of a word always comes at a later edge than its acceptance,
   // so checking before noting the new word keeps the queue order right.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) board.check_result(rsp_data);
         if (start && !busy) board.take_word(req_data);
      end
   end

   // Hard stop.
   initial begin
      #8_000_000;
      $display("Some tests failed");
      $finish;
   end

   // Drive one word at the falling edge, then hold it until an edge with
   // busy low takes it. An optional gap drops start first. Each falling edge
   // sees at most one assignment to start, so a word that follows directly
   // keeps start high without a glitch.
   task automatic send_word(input logic [1:0] kind, input logic [NOTE_W-1:0] note);
      if ($urandom_range(0, 99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
         repeat ($urandom_range(0, 6)) @(negedge clock);
      end
      @(negedge clock);
      req_data <= '{req_type: kind, note_number: note};
      start    <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   // random note already in the predicted list; caller makes sure it is not empty
   function automatic logic [NOTE_W-1:0] pick_held();
      return board.held[$urandom_range(0, board.held_len - 1)];
   endfunction

   task automatic shuffle_notes();
      int                j;
      logic [NOTE_W-1:0] t;
      foreach (order[i]) order[i] = NOTE_W'(i);
      for (int i = MAX_NOTES - 1; i > 0; i--) begin
         j        = $urandom_range(0, i);
         t        = order[i];
         order[i] = order[j];
         order[j] = t;
      end
   endtask

   // Playing style traffic: notes mostly from a small moving pool so that
   // re-presses and releases of held notes are common; a fifth anywhere in the
   // range. Releases favor held notes to hit removal from the middle of the list.
   // A few ignored kinds are mixed in as noise and not counted.
   task automatic play_chords(input int words);
      int                done_words;
      int                base;
      int                span;
      logic [1:0]        kind;
      logic [NOTE_W-1:0] note;
      done_words = 0;
      base       = 0;
      span       = 2;
      while (done_words < words) begin
         if (done_words % 32 == 0) begin
            base = $urandom_range(0, 127);
            span = $urandom_range(2, 12);
         end
         if ($urandom_range(0, 99) < 5) begin
            send_word($urandom_range(0, 1) ? REQ_OTHER : REQ_SPARE, NOTE_W'($urandom));
         end else begin
            if ($urandom_range(0, 99) < 20) note = NOTE_W'($urandom);
            else note = NOTE_W'(base + $urandom_range(0, span - 1));
            if ($urandom_range(0, 99) < 60) begin
               kind = REQ_NOTE_ON;
            end else begin
               kind = REQ_NOTE_OFF;
               if (board.held_len != 0 && $urandom_range(0, 9) < 7) note = pick_held();
            end
            send_word(kind, note);
            done_words++;
         end
      end
   endtask

   initial begin
      int phase_idle [4];
      int wait_cycles;
      phase_idle = '{0, 65, 0, 25};
      board      = new();
      idle_pct   = 0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // --- directed ---
      send_word(REQ_NOTE_OFF, 7'd5);     // release on empty list
      send_word(REQ_OTHER, 7'd127);      // ignored kinds on empty list
      send_word(REQ_SPARE, 7'd0);
      send_word(REQ_NOTE_ON, 7'd0);
      send_word(REQ_NOTE_ON, 7'd127);
      send_word(REQ_NOTE_ON, 7'd64);
      send_word(REQ_NOTE_ON, 7'd127);    // re-press from the middle
      send_word(REQ_NOTE_ON, 7'd0);      // re-press from the oldest slot
      send_word(REQ_NOTE_ON, 7'd0);      // re-press of the newest note
      send_word(REQ_NOTE_OFF, 7'd64);    // release of the oldest note
      send_word(REQ_NOTE_OFF, 7'd99);    // note not held
      send_word(REQ_NOTE_OFF, 7'd0);     // release of the newest note
      send_word(REQ_OTHER, 7'd85);       // ignored with notes held
      send_word(REQ_SPARE, 7'd42);
      send_word(REQ_NOTE_OFF, 7'd127);   // list empties
      send_word(REQ_NOTE_ON, 7'd42);
      send_word(REQ_NOTE_OFF, 7'd42);
      send_word(REQ_NOTE_ON, 7'd1);
      send_word(REQ_NOTE_ON, 7'd2);
      send_word(REQ_NOTE_ON, 7'd1);
      send_word(REQ_NOTE_OFF, 7'd2);
      send_word(REQ_NOTE_OFF, 7'd1);

      // --- random, one idle setting per phase ---
      for (int ph = 0; ph < 4; ph++) begin
         idle_pct = phase_idle[ph];
         if (ph == 1) begin
            // Fill all 128 notes in random order (count reaches 128, top bit of
            // held_count), re-press now and then, re-press once more when full,
            // then release everything in another random order, now and then twice.
            shuffle_notes();
            foreach (order[i]) begin
               send_word(REQ_NOTE_ON, order[i]);
               if ($urandom_range(0, 9) == 0) send_word(REQ_NOTE_ON, pick_held());
            end
            send_word(REQ_NOTE_ON, pick_held());
            shuffle_notes();
            foreach (order[i]) begin
               send_word(REQ_NOTE_OFF, order[i]);
               if ($urandom_range(0, 15) == 0) send_word(REQ_NOTE_OFF, order[i]);
            end
         end else begin
            play_chords(215);
         end
      end

      @(negedge clock);
      start <= 1'b0;

      // drain: wait until every predicted report word has arrived
      wait_cycles = 0;
      while (board.expected_reports.size() != 0 && wait_cycles < 2000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (150) @(posedge clock);
      if (board.expected_reports.size() != 0)
         board.report_mismatch($sformatf("%0d report words never arrived",
                                         board.expected_reports.size()));

      if (board.fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
